>>> hdl/eds_pkg.sv
// Shared field widths, opcodes and status codes of the earliest-deadline suspend table.
package eds_pkg;

  localparam int OPC_W    = 2;
  localparam int ID_W     = 16;
  localparam int DELAY_W  = 31;
  localparam int STATUS_W = 3;
  localparam int HELD_W   = 8;
  localparam int CFG_W    = 8;

  localparam logic [CFG_W-1:0] MAX_COUNT_RST = CFG_W'(100);

  localparam logic [OPC_W-1:0] OP_SUSPEND = 2'd0;
  localparam logic [OPC_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OPC_W-1:0] OP_GET     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_READY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WAIT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NA      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RESUMED = 3'd6;

endpackage

>>> hdl/eds_in_if.sv
// Request channel of the suspend table: valid/ready and one request.
interface eds_in_if;
  import eds_pkg::*;

  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [ID_W-1:0]    worker_id;
  logic [DELAY_W-1:0] delay_ms;

  modport source (output valid, output opcode, output worker_id, output delay_ms,
                  input ready);
  modport sink   (input valid, input opcode, input worker_id, input delay_ms,
                  output ready);
endinterface

>>> hdl/eds_out_if.sv
// Result channel of the suspend table: valid/ready and one result.
interface eds_out_if;
  import eds_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     worker_out;
  logic [HELD_W-1:0]   held_count;

  modport source (output valid, output status, output worker_out, output held_count,
                  input ready);
  modport sink   (input valid, input status, input worker_out, input held_count,
                  output ready);
endinterface

>>> hdl/eds_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module eds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/earliest_deadline_suspend_table.sv
// Earliest-deadline suspend table: top level with slot memory, ready FIFO and scan engine.
//
// The block keeps up to CAPACITY suspended workers, each with a wake deadline on a
// millisecond clock of TIME_BITS bits, in a slot memory, plus a FIFO memory of woken
// ids. Every request on in_ch gives exactly one result on out_ch. A tick, a rejected
// suspend and a get answered wait or not_available are answered from the idle state
// with no scan. An accepted suspend and a successful get each scan all held entries
// before the next request is accepted: the slot memory has one read port, and the
// scan that finds the earliest unreleased deadline (and, for a get, finds and removes
// the entry holding the popped id, shifting later entries down) reads one slot per
// cycle. Neither memory needs clearing after reset, so the block takes requests from
// the first cycle out of reset. max_count is written through cfg_we/cfg_wdata; the
// user must write it while the block is idle, which the block itself does not enforce.
module earliest_deadline_suspend_table #(
  parameter int CAPACITY  = 128,
  parameter int TIME_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  eds_in_if.sink                     in_ch,
  eds_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [eds_pkg::CFG_W-1:0]  cfg_wdata
);
  import eds_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SLOT_W = TIME_BITS + ID_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIFO = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // control state
  logic [1:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     max_count_r, max_count_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 armed_r, armed_nxt;
  logic [IDX_W-1:0]     armed_slot_r, armed_slot_nxt;
  logic [TIME_BITS-1:0] fire_r, fire_nxt;
  logic                 out_valid_r, out_valid_nxt;
  // scan engine
  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]     proc_idx_r, proc_idx_nxt;
  logic                 pend_r, pend_nxt;
  logic                 found_r, found_nxt;
  logic                 match_en_r, match_en_nxt;
  logic                 best_vld_r, best_vld_nxt;
  // payload
  logic [TIME_BITS-1:0] best_dl_r, best_dl_nxt;
  logic [IDX_W-1:0]     best_slot_r, best_slot_nxt;
  logic [ID_W-1:0]      best_worker_r, best_worker_nxt;
  logic [ID_W-1:0]      want_r, want_nxt;
  logic [TIME_BITS-1:0] armed_dl_r, armed_dl_nxt;
  logic [ID_W-1:0]      armed_worker_r, armed_worker_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ID_W-1:0]      out_worker_r, out_worker_nxt;
  logic [HELD_W-1:0]    out_held_r, out_held_nxt;

  // memory ports
  logic                 slot_we;
  logic [IDX_W-1:0]     slot_waddr;
  logic [SLOT_W-1:0]    slot_wdata;
  logic [SLOT_W-1:0]    slot_rdata;
  logic                 fifo_we;
  logic [ID_W-1:0]      fifo_rdata;

  // datapath helpers
  logic                 in_fire;
  logic                 out_free;
  logic [TIME_BITS-1:0] now_inc;
  logic [IDX_W-1:0]     head_inc;
  logic [IDX_W-1:0]     tail_inc;
  logic                 rd_released;
  logic [TIME_BITS-1:0] rd_dl;
  logic [ID_W-1:0]      rd_worker;
  logic                 is_match;
  logic [IDX_W-1:0]     rd_pos;
  logic [CNT_W-1:0]     count_done;
  logic                 res_load;
  logic [STATUS_W-1:0]  res_status;
  logic [ID_W-1:0]      res_worker;
  logic [CNT_W-1:0]     res_held;

  eds_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (slot_rdata)
  );

  eds_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail_r),
    .wdata (armed_worker_r),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  // Slot word: released flag on top, then deadline, then worker id.
  assign rd_released = slot_rdata[SLOT_W-1];
  assign rd_dl       = slot_rdata[SLOT_W-2:ID_W];
  assign rd_worker   = slot_rdata[ID_W-1:0];

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign now_inc  = now_r + TIME_BITS'(1);
  assign head_inc = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + IDX_W'(1);
  assign tail_inc = (tail_r == IDX_W'(CAPACITY - 1)) ? '0 : tail_r + IDX_W'(1);

  // First entry holding the wanted id is dropped; entries after it move down one slot.
  assign is_match   = match_en_r && !found_r && (rd_worker == want_r);
  assign rd_pos     = found_r ? proc_idx_r - IDX_W'(1) : proc_idx_r;
  assign count_done = found_r ? count_r - CNT_W'(1) : count_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.worker_out = out_worker_r;
  assign out_ch.held_count = out_held_r;

  always_comb begin
    state_nxt        = state_r;
    max_count_nxt    = cfg_we ? cfg_wdata : max_count_r;
    count_nxt        = count_r;
    fill_nxt         = fill_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    now_nxt          = now_r;
    armed_nxt        = armed_r;
    armed_slot_nxt   = armed_slot_r;
    fire_nxt         = fire_r;
    rd_idx_nxt       = rd_idx_r;
    proc_idx_nxt     = proc_idx_r;
    pend_nxt         = pend_r;
    found_nxt        = found_r;
    match_en_nxt     = match_en_r;
    best_vld_nxt     = best_vld_r;
    best_dl_nxt      = best_dl_r;
    best_slot_nxt    = best_slot_r;
    best_worker_nxt  = best_worker_r;
    want_nxt         = want_r;
    armed_dl_nxt     = armed_dl_r;
    armed_worker_nxt = armed_worker_r;
    slot_we          = 1'b0;
    slot_waddr       = armed_slot_r;
    slot_wdata       = slot_rdata;
    fifo_we          = 1'b0;
    res_load         = 1'b0;
    res_status       = ST_IDLE;
    res_worker       = '0;
    res_held         = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.opcode)
            OP_SUSPEND: begin
              if (CMP_W'(count_r) >= CMP_W'(max_count_r) ||
                  count_r >= CNT_W'(CAPACITY)) begin
                res_load   = 1'b1;
                res_status = ST_FULL;
              end else begin
                // append at the end of the table, then rescan for the earliest
                slot_we      = 1'b1;
                slot_waddr   = count_r[IDX_W-1:0];
                slot_wdata   = {1'b0, now_r + TIME_BITS'(in_ch.delay_ms), in_ch.worker_id};
                count_nxt    = count_r + CNT_W'(1);
                rd_idx_nxt   = '0;
                proc_idx_nxt = '0;
                pend_nxt     = 1'b0;
                found_nxt    = 1'b0;
                best_vld_nxt = 1'b0;
                match_en_nxt = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            OP_TICK: begin
              now_nxt  = now_inc;
              res_load = 1'b1;
              if (armed_r && now_inc >= fire_r) begin
                // release the armed worker: queue its id and flag the slot
                if (fill_r < CNT_W'(CAPACITY)) begin
                  fifo_we  = 1'b1;
                  tail_nxt = tail_inc;
                  fill_nxt = fill_r + CNT_W'(1);
                end
                slot_we    = 1'b1;
                slot_waddr = armed_slot_r;
                slot_wdata = {1'b1, armed_dl_r, armed_worker_r};
                armed_nxt  = 1'b0;
                res_status = ST_RESUMED;
                res_worker = armed_worker_r;
              end
            end
            OP_GET: begin
              if (count_r == '0) begin
                res_load   = 1'b1;
                res_status = ST_NA;
              end else if (fill_r == '0) begin
                res_load   = 1'b1;
                res_status = ST_WAIT;
              end else begin
                // pop: the FIFO memory has sampled the old head on this edge
                head_nxt  = head_inc;
                fill_nxt  = fill_r - CNT_W'(1);
                state_nxt = S_FIFO;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_FIFO: begin
        want_nxt     = fifo_rdata;
        rd_idx_nxt   = '0;
        proc_idx_nxt = '0;
        pend_nxt     = 1'b0;
        found_nxt    = 1'b0;
        best_vld_nxt = 1'b0;
        match_en_nxt = 1'b1;
        state_nxt    = S_SCAN;
      end

      S_SCAN: begin
        if (rd_idx_r < count_r) begin
          pend_nxt   = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          proc_idx_nxt = proc_idx_r + IDX_W'(1);
          if (is_match) begin
            found_nxt = 1'b1;
          end else begin
            if (found_r) begin
              slot_we    = 1'b1;
              slot_waddr = rd_pos;
              slot_wdata = slot_rdata;
            end
            if (!rd_released && (!best_vld_r || rd_dl < best_dl_r)) begin
              best_vld_nxt    = 1'b1;
              best_dl_nxt     = rd_dl;
              best_slot_nxt   = rd_pos;
              best_worker_nxt = rd_worker;
            end
          end
        end
        if (!pend_r && rd_idx_r == count_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          count_nxt = count_done;
          armed_nxt = best_vld_r;
          if (best_vld_r) begin
            armed_slot_nxt   = best_slot_r;
            armed_dl_nxt     = best_dl_r;
            armed_worker_nxt = best_worker_r;
            fire_nxt         = (best_dl_r > now_inc) ? best_dl_r : now_inc;
          end
          res_load   = 1'b1;
          res_status = match_en_r ? ST_READY : ST_ACCEPT;
          res_worker = match_en_r ? want_r : '0;
          res_held   = count_done;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold the result until taken; load a fresh one when produced
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_worker_nxt = out_worker_r;
    out_held_nxt   = out_held_r;
    if (res_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_worker_nxt = res_worker;
      out_held_nxt   = HELD_W'(res_held);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_count_r  <= MAX_COUNT_RST;
      count_r      <= '0;
      fill_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      now_r        <= '0;
      armed_r      <= 1'b0;
      armed_slot_r <= '0;
      fire_r       <= '0;
      out_valid_r  <= 1'b0;
      rd_idx_r     <= '0;
      proc_idx_r   <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      match_en_r   <= 1'b0;
      best_vld_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      max_count_r  <= max_count_nxt;
      count_r      <= count_nxt;
      fill_r       <= fill_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      now_r        <= now_nxt;
      armed_r      <= armed_nxt;
      armed_slot_r <= armed_slot_nxt;
      fire_r       <= fire_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_idx_r     <= rd_idx_nxt;
      proc_idx_r   <= proc_idx_nxt;
      pend_r       <= pend_nxt;
      found_r      <= found_nxt;
      match_en_r   <= match_en_nxt;
      best_vld_r   <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_dl_r      <= best_dl_nxt;
    best_slot_r    <= best_slot_nxt;
    best_worker_r  <= best_worker_nxt;
    want_r         <= want_nxt;
    armed_dl_r     <= armed_dl_nxt;
    armed_worker_r <= armed_worker_nxt;
    out_status_r   <= out_status_nxt;
    out_worker_r   <= out_worker_nxt;
    out_held_r     <= out_held_nxt;
  end

  // occupancy never exceeds the memories
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("table count beyond capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("ready queue fill beyond capacity");

  // the armed entry always lies inside the held part of the table
  a_armed_inside: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (CNT_W'(armed_slot_r) < count_r))
    else $error("armed slot outside the table");

  // the scan address never goes beyond the count of held entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= count_r))
    else $error("scan address past table end");

  // only a get scan removes an entry
  a_match_only_get: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> match_en_r)
    else $error("entry removed during a suspend scan");

endmodule
